// ----- design/rctl_pkg.sv -----
// shared constants and types for the relay channel timer block
package rctl_pkg;

   localparam int CHANNELS_DEF      = 8;
   localparam int SPECIAL_FUNCS_DEF = 4;
   localparam int CNT_W             = 24;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [2:0] CSR_OFF_FACT  = 3'd0;
   localparam logic [2:0] CSR_ON_FACT   = 3'd1;
   localparam logic [2:0] CSR_EXPONENTS = 3'd2;
   localparam logic [2:0] CSR_TIMER     = 3'd3;
   localparam logic [2:0] CSR_ROUTING   = 3'd4;
   localparam logic [2:0] CSR_MODES     = 3'd5;
   localparam logic [2:0] CSR_POLARITY  = 3'd6;

   localparam logic [1:0] KIND_LOGIC = 2'd0;
   localparam logic [1:0] KIND_BLOCK = 2'd1;
   localparam logic [1:0] LOGIC_OR   = 2'd1;
   localparam logic [1:0] LOGIC_AND  = 2'd2;
   localparam logic [1:0] ACT_OFF    = 2'd1;
   localparam logic [1:0] ACT_ON     = 2'd2;

   // classified command handed from front to back
   typedef struct packed {
      logic       tick;
      logic       eval;
      logic [2:0] ch;
      logic       value;
      logic       set_obj;
      logic [3:0] obj;
   } cmd_type;

endpackage

// ----- design/relay_channel_timer_logic_unit.sv -----
// top level of the eight-channel relay actuator with delays, staircase, logic and blocking
// A word is an object write or one base-time tick; each word gives exactly one result word
// with relay pins, changed-channel mask and feedback bits. The front end registers each word
// and passes it on into a two-entry queue; the back end handles an object write as evaluate,
// then publish, and a tick as take, walk the channels, then publish, since the delay
// counters are walked one channel per cycle through a single decrement-and-reload path.
// Results sit in an output register so the next word can be taken while one waits. The user
// must write registers through the csr_ port only while the block is idle; the block itself
// does not enforce this.
module relay_channel_timer_logic_unit
   import rctl_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int SPECIAL_FUNCS = SPECIAL_FUNCS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [3:0]  req_object_number,
   input  logic        req_object_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_relay_pins,
   output logic [7:0]  rsp_feedback_mask,
   output logic [7:0]  rsp_feedback_values,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // configuration registers
   logic [63:0] off_ff, on_ff;
   logic [39:0] exp_ff;
   logic [15:0] tmode_ff, pol_ff;
   logic [31:0] route_ff;
   logic [35:0] modes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0; on_ff <= '0; exp_ff <= '0; tmode_ff <= '0;
         route_ff <= '0; modes_ff <= '0; pol_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OFF_FACT:  off_ff   <= csr_data;
            CSR_ON_FACT:   on_ff    <= csr_data;
            CSR_EXPONENTS: exp_ff   <= csr_data[39:0];
            CSR_TIMER:     tmode_ff <= csr_data[15:0];
            CSR_ROUTING:   route_ff <= csr_data[31:0];
            CSR_MODES:     modes_ff <= csr_data[35:0];
            CSR_POLARITY:  pol_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // front end to queue
   logic    f_valid, f_stall, b_valid, b_stall;
   cmd_type f_cmd, b_cmd;

   rctl_front #(.CHANNELS(CHANNELS), .SPECIAL_FUNCS(SPECIAL_FUNCS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_object_number,
      .req_object_value, .routing(route_ff),
      .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
   );

   rctl_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_cmd(f_cmd),
      .out_valid(b_valid), .out_stall(b_stall), .out_cmd(b_cmd)
   );

   rctl_back #(.CHANNELS(CHANNELS), .SPECIAL_FUNCS(SPECIAL_FUNCS)) u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd(b_cmd),
      .off_fact(off_ff), .on_fact(on_ff), .exps(exp_ff), .timer_mode(tmode_ff),
      .routing(route_ff), .modes(modes_ff), .polarity(pol_ff),
      .rsp_valid, .rsp_stall, .rsp_relay_pins, .rsp_feedback_mask, .rsp_feedback_values
   );

endmodule

// ----- design/rctl_front.sv -----
// front end: accepts words, looks up special-function routing and classifies them into commands
module rctl_front
   import rctl_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int SPECIAL_FUNCS = SPECIAL_FUNCS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_operation,
   input  logic [3:0]    req_object_number,
   input  logic          req_object_value,
   input  logic [31:0]   routing,
   output logic          cmd_valid,
   input  logic          cmd_stall,
   output cmd_type       cmd
);

   logic    full_ff, full_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;
   logic [3:0] tgt;

   assign req_stall = full_ff & cmd_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      tgt = 4'd0;
      if (req_object_number >= 4'd8 && req_object_number < 4'(8 + SPECIAL_FUNCS))
         tgt = routing[16 + 4 * (req_object_number[1:0]) +: 4];
      cmd_in         = '0;
      cmd_in.tick    = (req_operation == OP_TICK);
      cmd_in.obj     = req_object_number;
      cmd_in.value   = req_object_value;
      if (req_operation == OP_WRITE) begin
         if (req_object_number < 4'(CHANNELS)) begin
            cmd_in.set_obj = 1'b1;
            cmd_in.eval    = 1'b1;
            cmd_in.ch      = req_object_number[2:0];
         end else if (req_object_number >= 4'd8 &&
                      req_object_number < 4'(8 + SPECIAL_FUNCS)) begin
            cmd_in.set_obj = 1'b1;
            if (tgt >= 4'd1 && tgt <= 4'(CHANNELS)) begin
               cmd_in.eval = 1'b1;
               cmd_in.ch   = 3'(tgt - 4'd1);
            end
         end
      end
      full_in = full_ff;
      if (full_ff && !cmd_stall) full_in = 1'b0;
      if (take) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (take) cmd_ff <= cmd_in;
   end

   assign cmd_valid = full_ff;
   assign cmd       = cmd_ff;

endmodule

// ----- design/rctl_queue.sv -----
// short command queue between front and back ends
module rctl_queue
   import rctl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_stall,
   output cmd_type out_cmd
);

   cmd_type mem_ff [QUEUE_DEPTH];
   logic    wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_stall  = (cnt_ff == 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = mem_ff[rp_ff];
   assign push      = in_valid & ~in_stall;
   assign pop       = out_valid & ~out_stall;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end

endmodule

// ----- design/rctl_back.sv -----
// back end: special functions, delay timers and output register
module rctl_back
   import rctl_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int SPECIAL_FUNCS = SPECIAL_FUNCS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_stall,
   input  cmd_type     cmd,
   input  logic [63:0] off_fact,
   input  logic [63:0] on_fact,
   input  logic [39:0] exps,
   input  logic [15:0] timer_mode,
   input  logic [31:0] routing,
   input  logic [35:0] modes,
   input  logic [15:0] polarity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_relay_pins,
   output logic [7:0]  rsp_feedback_mask,
   output logic [7:0]  rsp_feedback_values
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TICK = 3'd1;
   localparam logic [2:0] ST_DONE = 3'd2;
   localparam logic [7:0] CHMASK  = 8'((1 << CHANNELS) - 1);

   logic [2:0]       state_ff, state_in;
   logic [2:0]       tch_ff, tch_in;
   logic [7:0]       out_ff, out_in, last_ff, last_in, run_ff, run_in;
   logic [11:0]      obj_ff, obj_in;
   logic [3:0]       blk_ff, blk_in;
   logic [CNT_W-1:0] cnt_ff [8];
   logic [CNT_W-1:0] cnt_wr;
   logic             cnt_we;
   logic [2:0]       cnt_idx;
   logic             rv_ff, rv_in;
   logic [7:0]       pins_ff, pins_in, mask_ff, mask_in, fbv_ff, fbv_in;
   logic             take;

   // compute the delay counter load value of one channel
   function automatic logic [CNT_W-1:0] load_val(input logic [2:0] ch,
                                                  input logic [7:0] f,
                                                  input logic [39:0] ex);
      logic [7:0] b;
      logic [3:0] e;
      logic [2:0] bs;
      bs = 3'((4'(ch) + 4'd1) >> 1);
      b  = ex[8 * bs +: 8];
      e  = ch[0] ? b[3:0] : b[7:4];
      return CNT_W'({24'd0, f} << e);
   endfunction

   // timer logic on one channel; updates output, run and counter load
   task automatic timer_logic(input logic [2:0] ch, input logic v,
                              inout logic [7:0] ob, inout logic [7:0] rb,
                              inout logic ld, inout logic [CNT_W-1:0] lv);
      logic [7:0] offf, onf;
      logic on;
      offf = off_fact[8 * ch +: 8];
      onf  = on_fact[8 * ch +: 8];
      on   = ob[ch];
      if (!timer_mode[ch]) begin
         if (on && offf != 0 && !v) begin
            ld = 1'b1; lv = load_val(ch, offf, exps); rb[ch] = 1'b1;
         end
         if (!on && onf != 0 && v) begin
            ld = 1'b1; lv = load_val(ch, onf, exps); rb[ch] = 1'b1;
         end
      end else begin
         if (onf == 0) begin
            if (!on && v) begin
               ob[ch] = 1'b1;
               ld = 1'b1; lv = load_val(ch, offf, exps); rb[ch] = 1'b1;
            end
         end else begin
            if (!on && v) begin
               ld = 1'b1; lv = load_val(ch, onf, exps); rb[ch] = 1'b1;
            end
            if (on && v) begin
               ld = 1'b1; lv = load_val(ch, offf, exps); rb[ch] = 1'b1;
            end
         end
         if (ob[ch] && !v && !timer_mode[8 + ch] && rb[ch]) begin
            rb[ch] = 1'b0;
            ob[ch] = 1'b0;
         end
      end
   endtask

   assign take      = cmd_valid & ~cmd_stall;
   assign cmd_stall = (state_ff != ST_IDLE);

   always_comb begin
      logic v, hold, ld, st, stop;
      logic [CNT_W-1:0] lv;
      logic [7:0] ob, rb;
      logic [3:0] bf;
      logic [11:0] objs;
      logic [1:0] a;
      state_in = state_ff;
      tch_in   = tch_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      run_in   = run_ff;
      obj_in   = obj_ff;
      blk_in   = blk_ff;
      rv_in    = rv_ff & rsp_stall;
      pins_in  = pins_ff;
      mask_in  = mask_ff;
      fbv_in   = fbv_ff;
      cnt_we   = 1'b0;
      cnt_idx  = 3'd0;
      cnt_wr   = '0;
      ob = out_ff; rb = run_ff; bf = blk_ff; objs = obj_ff;
      v = 1'b0; hold = 1'b0; ld = 1'b0; lv = '0; st = 1'b0; stop = 1'b0; a = 2'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd.tick) begin
                  tch_in   = 3'd0;
                  state_in = ST_TICK;
               end else begin
                  if (cmd.set_obj) objs[cmd.obj] = cmd.value;
                  obj_in = objs;
                  if (cmd.eval) begin
                     v = objs[cmd.ch];
                     for (int sf = 0; sf < SPECIAL_FUNCS; sf++) begin
                        if (!stop && routing[4 * sf +: 4] == 4'(cmd.ch) + 4'd1) begin
                           st = objs[8 + sf];
                           if (modes[2 * sf +: 2] == KIND_LOGIC) begin
                              if (modes[8 + 2 * sf +: 2] == LOGIC_OR)  v = v | st;
                              if (modes[8 + 2 * sf +: 2] == LOGIC_AND) v = v & st;
                           end else if (modes[2 * sf +: 2] == KIND_BLOCK) begin
                              if (st ^ modes[16 + sf]) begin
                                 hold = 1'b1; stop = 1'b1;
                                 if (!bf[sf]) begin
                                    bf[sf] = 1'b1;
                                    rb[cmd.ch] = 1'b0;
                                    a = modes[20 + 4 * sf +: 2];
                                    if (a == ACT_OFF) ob[cmd.ch] = 1'b0;
                                    if (a == ACT_ON)  ob[cmd.ch] = 1'b1;
                                 end
                              end else if (bf[sf]) begin
                                 bf[sf] = 1'b0;
                                 a = modes[22 + 4 * sf +: 2];
                                 if (a == ACT_OFF || a == ACT_ON) v = (a == ACT_ON);
                                 else begin
                                    hold = 1'b1; stop = 1'b1;
                                 end
                              end
                           end
                        end
                     end
                     if (!hold) begin
                        timer_logic(cmd.ch, v, ob, rb, ld, lv);
                        if (!rb[cmd.ch]) ob[cmd.ch] = v;
                     end
                  end
                  out_in  = ob & CHMASK;
                  run_in  = rb;
                  blk_in  = bf;
                  cnt_we  = ld;
                  cnt_idx = cmd.ch;
                  cnt_wr  = lv;
                  state_in = ST_DONE;
               end
            end
         end
         ST_TICK: begin
            if (rb[tch_ff]) begin
               cnt_idx = tch_ff;
               cnt_we  = 1'b1;
               if (cnt_ff[tch_ff] <= CNT_W'(1)) begin
                  cnt_wr = '0;
                  rb[tch_ff] = 1'b0;
                  ob[tch_ff] = ~ob[tch_ff];
                  timer_logic(tch_ff, ob[tch_ff], ob, rb, ld, lv);
                  if (ld) cnt_wr = lv;
               end else begin
                  cnt_wr = cnt_ff[tch_ff] - CNT_W'(1);
               end
            end
            out_in = ob;
            run_in = rb;
            tch_in = tch_ff + 3'd1;
            if (tch_ff == 3'(CHANNELS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               ob       = out_ff & CHMASK;
               out_in   = ob;
               mask_in  = (ob ^ last_ff) & CHMASK;
               last_in  = ob;
               pins_in  = (ob ^ polarity[7:0]) & CHMASK;
               fbv_in   = (ob ^ polarity[15:8]) & CHMASK;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tch_ff   <= 3'd0;
         out_ff   <= 8'd0;
         last_ff  <= 8'd0;
         run_ff   <= 8'd0;
         obj_ff   <= 12'd0;
         blk_ff   <= 4'd0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         tch_ff   <= tch_in;
         out_ff   <= out_in;
         last_ff  <= last_in;
         run_ff   <= run_in;
         obj_ff   <= obj_in;
         blk_ff   <= blk_in;
         rv_ff    <= rv_in;
         if (cnt_we) cnt_ff[cnt_idx] <= cnt_wr;
      end
      pins_ff <= pins_in;
      mask_ff <= mask_in;
      fbv_ff  <= fbv_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_relay_pins      = pins_ff;
   assign rsp_feedback_mask   = mask_ff;
   assign rsp_feedback_values = fbv_ff;

endmodule

// ----- bench/relay_channel_timer_checker.sv -----
// result checker for the relay channel timer block: watches request, result and register ports and predicts results
`timescale 1ns / 1ps
module relay_channel_timer_checker
   import rctl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [3:0]  req_object_number,
   input  logic        req_object_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_relay_pins,
   input  logic [7:0]  rsp_feedback_mask,
   input  logic [7:0]  rsp_feedback_values,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0] pins;
      logic [7:0] mask;
      logic [7:0] fb;
   } relay_word_type;

   relay_word_type pending_words[$];

   logic [63:0] off_fact, on_fact;
   logic [39:0] exps;
   logic [15:0] tmode;
   logic [31:0] routing;
   logic [35:0] modes;
   logic [15:0] polarity;

   logic [7:0]  outs, last_outs, blocked, running;
   logic [11:0] objs;
   logic [23:0] counters[8];

   assign pending_count = pending_words.size();

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic load_delay(input int ch, input logic [7:0] factor);
      logic [7:0] b;
      logic [3:0] e;
      b = exps[8*((ch+1)/2) +: 8];
      e = (ch & 1) ? b[3:0] : b[7:4];
      counters[ch] = 24'({24'd0, factor} << e);
      running[ch] = 1'b1;
   endtask

   task automatic run_timers(input int ch, input logic v);
      logic [7:0] offf, onf;
      logic on;
      offf = off_fact[8*ch +: 8];
      onf  = on_fact[8*ch +: 8];
      on   = outs[ch];
      if (!tmode[ch]) begin
         if (on && offf != 0 && !v) load_delay(ch, offf);
         if (!on && onf != 0 && v) load_delay(ch, onf);
      end else begin
         // staircase
         if (onf == 0) begin
            if (!on && v) begin
               outs[ch] = 1'b1;
               load_delay(ch, offf);
            end
         end else begin
            if (!on && v) load_delay(ch, onf);
            if (on && v) load_delay(ch, offf);
         end
         if (outs[ch] && !v && !tmode[8+ch] && running[ch]) begin
            running[ch] = 1'b0;
            outs[ch] = 1'b0;
         end
      end
   endtask

   // returns 1 when the channel holds
   function automatic logic apply_specials(input int ch, inout logic v);
      logic [1:0] kind, lt, a;
      logic [3:0] acts;
      logic st;
      for (int sf = 0; sf < 4; sf++) begin
         if (routing[4*sf +: 4] != 4'(ch + 1)) continue;
         kind = modes[2*sf +: 2];
         st = objs[8+sf];
         if (kind == KIND_LOGIC) begin
            lt = modes[8+2*sf +: 2];
            if (lt == LOGIC_OR) v = v | st;
            if (lt == LOGIC_AND) v = v & st;
         end else if (kind == KIND_BLOCK) begin
            acts = modes[20+4*sf +: 4];
            if (st ^ modes[16+sf]) begin
               if (blocked[sf]) return 1'b1;
               blocked[sf] = 1'b1;
               running[ch] = 1'b0;
               if (acts[1:0] == ACT_OFF) outs[ch] = 1'b0;
               if (acts[1:0] == ACT_ON) outs[ch] = 1'b1;
               return 1'b1;
            end else if (blocked[sf]) begin
               a = acts[3:2];
               blocked[sf] = 1'b0;
               if (a != ACT_OFF && a != ACT_ON) return 1'b1;
               v = (a == ACT_ON);
            end
         end
      end
      return 1'b0;
   endfunction

   task automatic eval_channel(input int ch, input logic v0);
      logic v;
      v = v0;
      if (apply_specials(ch, v)) return;
      run_timers(ch, v);
      if (!running[ch]) outs[ch] = v;
   endtask

   task automatic predict_word(input logic op, input logic [3:0] num, input logic val);
      relay_word_type w;
      logic [3:0] tgt;
      if (op == OP_WRITE) begin
         if (num < 8) begin
            objs[num] = val;
            eval_channel(num, val);
         end else if (num < 12) begin
            objs[num] = val;
            tgt = routing[16+4*(num-8) +: 4];
            if (tgt >= 1 && tgt <= 8) eval_channel(tgt - 1, objs[tgt-1]);
         end
      end else begin
         for (int ch = 0; ch < 8; ch++) begin
            if (!running[ch]) continue;
            if (counters[ch] <= 1) begin
               counters[ch] = '0;
               running[ch] = 1'b0;
               outs[ch] = ~outs[ch];
               run_timers(ch, outs[ch]);
            end else begin
               counters[ch]--;
            end
         end
      end
      w.pins = outs ^ polarity[7:0];
      w.mask = outs ^ last_outs;
      w.fb   = outs ^ polarity[15:8];
      last_outs = outs;
      pending_words.push_back(w);
   endtask

   always @(posedge clock) begin
      relay_word_type want;
      if (reset) begin
         off_fact <= '0; on_fact <= '0; exps <= '0; tmode <= '0;
         routing <= '0; modes <= '0; polarity <= '0;
         outs <= '0; last_outs <= '0; blocked <= '0; running <= '0; objs <= '0;
         for (int i = 0; i < 8; i++) counters[i] <= '0;
         pending_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFF_FACT:  off_fact = csr_data;
               CSR_ON_FACT:   on_fact = csr_data;
               CSR_EXPONENTS: exps = csr_data[39:0];
               CSR_TIMER:     tmode = csr_data[15:0];
               CSR_ROUTING:   routing = csr_data[31:0];
               CSR_MODES:     modes = csr_data[35:0];
               CSR_POLARITY:  polarity = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_word(req_operation, req_object_number, req_object_value);
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $display("unexpected result word at %0t", $realtime);
               fail_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_relay_pins !== want.pins) report("relay_pins", rsp_relay_pins, want.pins);
               if (rsp_feedback_mask !== want.mask)
                  report("feedback_mask", rsp_feedback_mask, want.mask);
               if (rsp_feedback_values !== want.fb)
                  report("feedback_values", rsp_feedback_values, want.fb);
            end
         end
      end
   end

endmodule

// ----- bench/tb_relay_channel_timer_logic_unit.sv -----
// stimulus and verdict for the relay channel timer block
`timescale 1ns / 1ps
module tb_relay_channel_timer_logic_unit;
   import rctl_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_WRITE;
   logic [3:0]  req_object_number = '0;
   logic        req_object_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_relay_pins, rsp_feedback_mask, rsp_feedback_values;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count, pending_count;
   int          idle_cycles;
   bit          calm;   // stretch with no idling on either side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   relay_channel_timer_logic_unit u_dut (.*);

   relay_channel_timer_checker u_check (.*);

   // receiver stalls at random, about 8 in a hundred, except during the calm stretch
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 8);

   // watchdog: cycles without any accepted word or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // valid stays high after the write; the next word drops it
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait for every expected word, then let the tick walk finish
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // valid stays high after acceptance so words can follow back to back
   task automatic send_word(input logic op, input logic [3:0] num, input logic val);
      csr_valid <= 1'b0;
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_object_number <= num;
      req_object_value  <= val;
      do @(posedge clock); while (req_stall);
   endtask

   // exponent nibbles kept small so delays expire within a few dozen ticks
   function automatic logic [39:0] small_exps;
      logic [39:0] e;
      for (int i = 0; i < 10; i++) e[4*i +: 4] = 4'($urandom_range(2));
      return e;
   endfunction

   function automatic logic [63:0] small_factors;
      logic [63:0] f;
      for (int i = 0; i < 8; i++)
         f[8*i +: 8] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      return f;
   endfunction

   task automatic random_phase(input int count);
      logic [3:0] num;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 45) send_word(OP_TICK, 4'($urandom), 1'($urandom));
         else begin
            num = ($urandom_range(19) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(11));
            send_word(OP_WRITE, num, 1'($urandom));
         end
      end
   endtask

   initial begin
      calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: plain writes, invalid objects and ticks with no delays
      send_word(OP_WRITE, 4'd0, 1'b1);
      send_word(OP_WRITE, 4'd7, 1'b1);
      send_word(OP_WRITE, 4'd15, 1'b1);
      send_word(OP_WRITE, 4'd12, 1'b1);
      send_word(OP_TICK, 4'd0, 1'b0);
      send_word(OP_WRITE, 4'd0, 1'b0);
      drain;

      // on/off delays with zero and small exponents and an extreme factor, routing to every function
      write_reg(CSR_OFF_FACT, 64'h0102_0300_0101_01FF);
      write_reg(CSR_ON_FACT, 64'h0001_0200_0102_0100);
      write_reg(CSR_EXPONENTS, 40'h00_0010_0000);
      write_reg(CSR_TIMER, 16'h20_F0);
      write_reg(CSR_ROUTING, 32'h8531_8531);
      write_reg(CSR_MODES, 36'hE_6_5_0_9_2_1_5_4); // logic, block, block, block mix
      write_reg(CSR_POLARITY, 16'hA5_3C);
      send_word(OP_WRITE, 4'd1, 1'b1);
      send_word(OP_WRITE, 4'd8, 1'b1);   // OR input of channel 0 set
      send_word(OP_WRITE, 4'd0, 1'b1);   // channel 0 with its OR input set
      send_word(OP_WRITE, 4'd8, 1'b0);   // OR input of channel 0 cleared
      send_word(OP_WRITE, 4'd10, 1'b1);
      send_word(OP_WRITE, 4'd11, 1'b1);
      send_word(OP_WRITE, 4'd4, 1'b1);   // staircase
      for (int i = 0; i < 6; i++) send_word(OP_TICK, 4'd0, 1'b0);
      send_word(OP_WRITE, 4'd4, 1'b0);
      send_word(OP_WRITE, 4'd9, 1'b1);
      drain;

      // random phases under different settings, extremes included
      for (int p = 0; p < 12; p++) begin
         calm = (p == 3);
         write_reg(CSR_OFF_FACT, (p == 0) ? '1 : small_factors());
         write_reg(CSR_ON_FACT, (p == 0) ? '1 : small_factors());
         write_reg(CSR_EXPONENTS, (p == 0) ? 40'h00_0000_0000
                   : (p == 11) ? 40'hFF_FFFF_FFFF : small_exps());
         write_reg(CSR_TIMER, (p == 11) ? 16'hFFFF : 16'($urandom));
         write_reg(CSR_ROUTING, (p == 11) ? 32'hFFFF_FFFF : {$urandom} & 32'h9999_9999
                   | (32'($urandom_range(8)) << 16));
         write_reg(CSR_MODES, (p == 11) ? 36'hF_FFFF_FFFF : {$urandom, 4'($urandom)});
         write_reg(CSR_POLARITY, 16'($urandom));
         random_phase(155);
         drain;
      end

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
